// ----- design/assert_macros.svh -----
// Assertion macros shared by the arcsin series evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/asev_pkg.sv -----
// Shared types and constants of the arcsin series evaluator.
`timescale 1ns / 1ps
package asev_pkg;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 63;
    localparam int LEN_W   = 7;
    localparam int SHIFT_W = 6;
    localparam int MAG_W   = 31;

    localparam logic [MAG_W-1:0] MAG_CAP = 31'h7FFF_FFFF;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DIVZ  = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    // Request to the shared divider: floor((num << shift) / den), capped
    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [LEN_W-1:0]   len;
        logic [SHIFT_W-1:0] shift;
        logic [DEN_W-1:0]   den;
    } t_div_req;
endpackage

// ----- design/asev_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module asev_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    // Register the product
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

// ----- design/asev_div.sv -----
// Bit-serial restoring divider with saturation of the quotient.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module asev_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  asev_pkg::t_div_req       i_req,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [asev_pkg::MAG_W-1:0] o_quot
);
    import asev_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [MAG_W-1:0] r_q;
    logic             r_ovf;
    logic [LEN_W:0]   r_steps;
    logic             r_busy;

    logic [NUM_W-1:0] n_trial;
    logic             n_ge;
    logic [NUM_W-1:0] n_rem;
    logic [MAG_W-1:0] n_q;
    logic             n_ovf;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        n_trial = {r_rem[NUM_W-2:0], r_num[NUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_rem   = n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
        n_q     = {r_q[MAG_W-2:0], n_ge};
        n_ovf   = r_ovf | r_q[MAG_W-1];
    end

    // Load, iterate and deliver the capped quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (r_busy) begin
                r_num   <= {r_num[NUM_W-2:0], 1'b0};
                r_rem   <= n_rem;
                r_q     <= n_q;
                r_ovf   <= n_ovf;
                r_steps <= r_steps - 1'b1;
                if (r_steps == 1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_quot <= n_ovf ? MAG_CAP : n_q;
                end
            end else if (i_req.start) begin
                r_num   <= i_req.num << (LEN_W'(NUM_W) - i_req.len);
                r_rem   <= '0;
                r_den   <= i_req.den;
                r_q     <= '0;
                r_ovf   <= 1'b0;
                r_steps <= {1'b0, i_req.len} + (LEN_W+1)'(i_req.shift);
                r_busy  <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy;

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_req.start && r_busy, "divider restarted while busy")
    `ASSERT_CLK(a_rem_below, i_clk, i_rst_n, r_busy |-> (r_rem < {1'b0, r_den}), "remainder not below divisor")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, o_done |-> !r_busy, "done while still busy")
endmodule

// ----- design/arcsin_series_evaluator_core.sv -----
// Top level: sequencer of the arcsin series evaluator around a shared multiplier and divider.
// A zero argument with cmd 1 is answered from idle; other requests run the series loop on the bit-serial divider.
// Throughput: one transaction at a time; start is taken only while busy is low.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, active low) returns the sequencer to idle and drops the strobe.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arcsin_series_evaluator_core #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [31:0] i_arg_value,
    input  logic [30:0]        i_tolerance,
    output logic               o_valid,
    output logic signed [31:0] o_sum_value,
    output logic [6:0]         o_terms_used,
    output logic [1:0]         o_status
);
    import asev_pkg::*;

    localparam int IW = $clog2(2*MAX_TERMS + 2);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int PL = MAG_W + 2*IW;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_DIV0, S_CHECK, S_II, S_D, S_PROD, S_SCALE, S_DIVA, S_DIVB
    } t_state;

    t_state            r_state;
    logic              r_cmd;
    logic              r_neg;
    logic [31:0]       r_xmag;
    logic [30:0]       r_tol;
    logic [MAG_W-1:0]  r_sq;
    logic [DEN_W-1:0]  r_xx;
    logic [31:0]       r_t;
    logic [IW-1:0]     r_i;
    logic [2*IW-1:0]   r_ii;
    logic [2*IW-1:0]   r_d;
    logic signed [31:0] r_sum;
    logic [CW-1:0]     r_cnt;

    logic [31:0]       n_xmag;
    logic [31:0]       n_mul_a;
    logic [31:0]       n_mul_b;
    logic [63:0]       w_prod;
    logic [MAG_W-1:0]  n_pcap;
    logic [MAG_W-1:0]  n_sq;
    logic signed [33:0] n_acc;
    logic signed [31:0] n_sum;
    t_div_req          n_div;
    logic              w_div_busy;
    logic              w_div_done;
    logic [MAG_W-1:0]  w_quot;

    asev_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (w_prod)
    );

    asev_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Derive magnitude, capped products and saturated sum
    always_comb begin
        n_xmag = i_arg_value[31] ? (~i_arg_value + 32'd1) : i_arg_value;
        n_sq   = ((w_prod >> FRAC_BITS) > 64'(MAG_CAP)) ? MAG_CAP
                 : MAG_W'(w_prod >> FRAC_BITS);
        n_pcap = n_sq;
        n_acc  = r_neg ? (34'(r_sum) - $signed({2'b00, r_t}))
                       : (34'(r_sum) + $signed({2'b00, r_t}));
        if (n_acc > 34'sd2147483647) begin
            n_sum = 32'sh7FFF_FFFF;
        end else if (n_acc < -34'sd2147483648) begin
            n_sum = 32'sh8000_0000;
        end else begin
            n_sum = n_acc[31:0];
        end
    end

    // Steer the shared multiplier and divider by state
    always_comb begin
        n_mul_a   = '0;
        n_mul_b   = '0;
        n_div     = '0;
        n_div.den = r_xx;
        unique case (r_state)
            S_IDLE: begin
                n_mul_a = n_xmag;
                n_mul_b = n_xmag;
            end
            S_SQ: begin
                n_div.start = r_cmd;
                n_div.num   = NUM_W'(1);
                n_div.len   = LEN_W'(1);
                n_div.shift = SHIFT_W'(2*FRAC_BITS);
                n_div.den   = DEN_W'(r_xmag);
            end
            S_CHECK: begin
                n_mul_a = 32'(r_i);
                n_mul_b = 32'(r_i);
            end
            S_II: begin
                n_mul_a = 32'(r_i) + 32'd1;
                n_mul_b = 32'(r_i) + 32'd2;
            end
            S_D: begin
                n_mul_a = r_t;
                n_mul_b = r_cmd ? 32'(r_ii) : 32'(r_sq);
            end
            S_PROD: begin
                n_mul_a     = 32'(n_pcap);
                n_mul_b     = 32'(r_ii);
                n_div.start = r_cmd;
                n_div.num   = w_prod;
                n_div.len   = LEN_W'(PL);
                n_div.den   = DEN_W'(r_d);
            end
            S_SCALE: begin
                n_div.start = 1'b1;
                n_div.num   = w_prod;
                n_div.len   = LEN_W'(PL);
                n_div.den   = DEN_W'(r_d);
            end
            S_DIVA: begin
                n_div.start = w_div_done && r_cmd;
                n_div.num   = NUM_W'(w_quot);
                n_div.len   = LEN_W'(MAG_W);
                n_div.shift = SHIFT_W'(2*FRAC_BITS);
                n_div.den   = r_xx;
            end
            default: begin
            end
        endcase
    end

    // Hold state, run the series loop and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd  <= i_cmd;
                        r_neg  <= i_arg_value[31];
                        r_xmag <= n_xmag;
                        r_tol  <= i_tolerance;
                        r_i    <= IW'(1);
                        r_sum  <= '0;
                        r_cnt  <= '0;
                        if (i_cmd && (i_arg_value == 32'sd0)) begin
                            o_valid      <= 1'b1;
                            o_sum_value  <= '0;
                            o_terms_used <= '0;
                            o_status     <= STATUS_DIVZ;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_xx    <= w_prod[DEN_W-1:0];
                    r_sq    <= n_sq;
                    r_t     <= r_xmag;
                    r_state <= r_cmd ? S_DIV0 : S_CHECK;
                end
                S_DIV0: begin
                    if (w_div_done) begin
                        r_t     <= 32'(w_quot);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_t > 32'(r_tol)) begin
                        if (r_cnt >= CW'(MAX_TERMS)) begin
                            o_valid      <= 1'b1;
                            o_sum_value  <= r_sum;
                            o_terms_used <= 7'(r_cnt);
                            o_status     <= STATUS_LIMIT;
                            r_state      <= S_IDLE;
                        end else begin
                            r_sum   <= n_sum;
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_II;
                        end
                    end else begin
                        o_valid      <= 1'b1;
                        o_sum_value  <= r_sum;
                        o_terms_used <= 7'(r_cnt);
                        o_status     <= STATUS_OK;
                        r_state      <= S_IDLE;
                    end
                end
                S_II: begin
                    r_ii    <= w_prod[2*IW-1:0];
                    r_state <= S_D;
                end
                S_D: begin
                    r_d     <= w_prod[2*IW-1:0];
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_state <= r_cmd ? S_DIVA : S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_DIVA;
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        if (r_cmd) begin
                            r_state <= S_DIVB;
                        end else begin
                            r_t     <= 32'(w_quot);
                            r_i     <= r_i + IW'(2);
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_DIVB: begin
                    if (w_div_done) begin
                        r_t     <= 32'(w_quot);
                        r_i     <= r_i + IW'(2);
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

    `ASSERT_CLK(a_valid_idle, i_clk, i_rst_n, o_valid |-> !busy, "result strobe while busy")
    `ASSERT_CLK(a_divz_zero, i_clk, i_rst_n, (o_valid && (o_status == STATUS_DIVZ)) |-> (o_sum_value == 32'sd0), "division by zero with nonzero sum")
    `ASSERT_CLK(a_wait_div, i_clk, i_rst_n, ((r_state == S_DIVB) && !w_div_done) |-> w_div_busy, "waiting on an idle divider")
endmodule
